>>> src/lmtc_pkg.sv
`default_nettype none

package lmtc_pkg;

  localparam int COUNT_W = 10;
  localparam int SUM_W = COUNT_W + 1;
  localparam int LINE_W = 8;
  localparam int ELAPSED_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [LINE_W:0] line_inc_t;
  typedef logic [1:0] mode_t;

  localparam mode_t MODE_HBLANK = 2'd0;
  localparam mode_t MODE_VBLANK = 2'd1;
  localparam mode_t MODE_OAM = 2'd2;
  localparam mode_t MODE_XFER = 2'd3;

  localparam count_t COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_IRQ_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OAM_IRQ_EN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VBLANK_IRQ_EN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ_EN = 3'd4;

  typedef struct packed {
    line_t line_compare;
    logic coin_irq_en;
    logic oam_irq_en;
    logic vblank_irq_en;
    logic hblank_irq_en;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    line_t line;
    logic coincidence;
    logic vblank_irq;
    logic stat_irq;
    logic draw;
  } result_t;

endpackage

`default_nettype wire

>>> src/lmtc_cfg_regs.sv
`default_nettype none

module lmtc_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [lmtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lmtc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output lmtc_pkg::cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lmtc_pkg::REG_LINE_COMPARE: begin
          cfg.line_compare <= cfg_data[lmtc_pkg::LINE_W-1:0];
        end
        lmtc_pkg::REG_COIN_IRQ_EN: begin
          cfg.coin_irq_en <= cfg_data[0];
        end
        lmtc_pkg::REG_OAM_IRQ_EN: begin
          cfg.oam_irq_en <= cfg_data[0];
        end
        lmtc_pkg::REG_VBLANK_IRQ_EN: begin
          cfg.vblank_irq_en <= cfg_data[0];
        end
        lmtc_pkg::REG_HBLANK_IRQ_EN: begin
          cfg.hblank_irq_en <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/lmtc_line_seq.sv
`default_nettype none

module lmtc_line_seq #(
  parameter int LINE_CYCLES = 456,
  parameter int TOTAL_LINES = 154,
  parameter int VISIBLE_LINES = 144,
  parameter int OAM_END = 80,
  parameter int TRANSFER_END = 252
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               fire,
  input  wire logic [lmtc_pkg::ELAPSED_W-1:0]     elapsed,
  input  wire lmtc_pkg::cfg_t                     cfg,
  output lmtc_pkg::result_t                       res
);

  localparam lmtc_pkg::sum_t LINE_C = lmtc_pkg::sum_t'(LINE_CYCLES);
  localparam lmtc_pkg::sum_t OAM_C = lmtc_pkg::sum_t'(OAM_END);
  localparam lmtc_pkg::sum_t XFER_C = lmtc_pkg::sum_t'(TRANSFER_END);
  localparam lmtc_pkg::line_inc_t TOTAL_C = lmtc_pkg::line_inc_t'(TOTAL_LINES);
  localparam lmtc_pkg::line_t VISIBLE_C = lmtc_pkg::line_t'(VISIBLE_LINES);

  lmtc_pkg::count_t cycle_count;
  lmtc_pkg::count_t cycle_count_next;
  lmtc_pkg::line_t line_number;
  lmtc_pkg::line_t line_number_next;
  lmtc_pkg::mode_t mode_flag;
  lmtc_pkg::mode_t mode_flag_next;
  logic coin_flag;
  logic coin_flag_next;

  lmtc_pkg::sum_t sum;
  lmtc_pkg::sum_t sum_red;
  lmtc_pkg::line_inc_t line_inc;
  logic wrap;
  logic vbl_pulse;
  logic stat_pulse;
  logic draw;

  always_comb begin
    sum = lmtc_pkg::sum_t'(cycle_count) + lmtc_pkg::sum_t'(elapsed);
    wrap = (sum >= LINE_C);
    sum_red = wrap ? (sum - LINE_C) : sum;
    line_inc = lmtc_pkg::line_inc_t'(line_number) + 1'b1;

    line_number_next = line_number;
    mode_flag_next = mode_flag;
    coin_flag_next = coin_flag;
    vbl_pulse = 1'b0;
    stat_pulse = 1'b0;
    draw = 1'b0;

    if (wrap) begin
      // line number never reaches TOTAL_LINES, so one compare does the modulo
      line_number_next = (line_inc == TOTAL_C) ? '0 : line_inc[lmtc_pkg::LINE_W-1:0];
      coin_flag_next = (line_number_next == cfg.line_compare);
      if (coin_flag_next && cfg.coin_irq_en) begin
        stat_pulse = 1'b1;
      end
      if (line_number_next == VISIBLE_C) begin
        mode_flag_next = lmtc_pkg::MODE_VBLANK;
        vbl_pulse = 1'b1;
        if (cfg.vblank_irq_en || cfg.oam_irq_en) begin
          stat_pulse = 1'b1;
        end
      end else if (line_number_next < VISIBLE_C) begin
        mode_flag_next = lmtc_pkg::MODE_OAM;
        if (cfg.oam_irq_en) begin
          stat_pulse = 1'b1;
        end
      end
    end else if (mode_flag == lmtc_pkg::MODE_OAM && sum >= OAM_C) begin
      mode_flag_next = lmtc_pkg::MODE_XFER;
    end else if (mode_flag == lmtc_pkg::MODE_XFER && sum >= XFER_C) begin
      mode_flag_next = lmtc_pkg::MODE_HBLANK;
      draw = 1'b1;
      if (cfg.hblank_irq_en) begin
        stat_pulse = 1'b1;
      end
    end

    // saturate when one line length was not enough
    cycle_count_next = sum_red[lmtc_pkg::SUM_W-1] ? lmtc_pkg::COUNT_MAX
                                                  : sum_red[lmtc_pkg::COUNT_W-1:0];

    res.mode = mode_flag_next;
    res.line = line_number_next;
    res.coincidence = coin_flag_next;
    res.vblank_irq = vbl_pulse;
    res.stat_irq = stat_pulse;
    res.draw = draw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_count <= '0;
      line_number <= '0;
      mode_flag <= lmtc_pkg::MODE_HBLANK;
      coin_flag <= 1'b0;
    end else if (fire) begin
      cycle_count <= cycle_count_next;
      line_number <= line_number_next;
      mode_flag <= mode_flag_next;
      coin_flag <= coin_flag_next;
    end
  end

endmodule

`default_nettype wire

>>> src/lcd_mode_timing_controller_top.sv
// Path: an input beat is taken into the input register, then its line/mode update
// is written into the result register; an output stall can hold it in between.
// Throughput: one beat per cycle while the output is not stalled.
// Reset: synchronous, active high; clears the cycle counter, line, mode, flag,
// configuration registers and both valid bits.
`default_nettype none

module lcd_mode_timing_controller_top #(
  parameter int LINE_CYCLES = 456,
  parameter int TOTAL_LINES = 154,
  parameter int VISIBLE_LINES = 144,
  parameter int OAM_END = 80,
  parameter int TRANSFER_END = 252
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [lmtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lmtc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [lmtc_pkg::ELAPSED_W-1:0]     elapsed_cycles,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              lcd_mode,
  output logic [lmtc_pkg::LINE_W-1:0]             current_line,
  output logic                                    coincidence,
  output logic                                    vblank_irq,
  output logic                                    stat_irq,
  output logic                                    draw_request
);

  lmtc_pkg::cfg_t cfg;
  lmtc_pkg::result_t res;
  logic in_q_valid;
  logic [lmtc_pkg::ELAPSED_W-1:0] elapsed_q;
  logic adv;
  logic fire;

  assign adv = !out_valid || !out_stall;
  assign fire = in_q_valid && adv;
  assign in_stall = in_q_valid && !adv;

  lmtc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmtc_line_seq #(
    .LINE_CYCLES   (LINE_CYCLES),
    .TOTAL_LINES   (TOTAL_LINES),
    .VISIBLE_LINES (VISIBLE_LINES),
    .OAM_END       (OAM_END),
    .TRANSFER_END  (TRANSFER_END)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .elapsed (elapsed_q),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      elapsed_q <= elapsed_cycles;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lcd_mode <= res.mode;
      current_line <= res.line;
      coincidence <= res.coincidence;
      vblank_irq <= res.vblank_irq;
      stat_irq <= res.stat_irq;
      draw_request <= res.draw;
    end
  end

endmodule

`default_nettype wire

>>> src/lmtc_checker.sv
`default_nettype none

module lmtc_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [1:0]                         lcd_mode,
  input wire logic [lmtc_pkg::LINE_W-1:0]        current_line,
  input wire logic                               vblank_irq,
  input wire logic                               draw_request
);

  // a held result beat keeps its mode and line
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(lcd_mode) && $stable(current_line))
    else $error("stalled result beat changed");

  a_vblank_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && vblank_irq |-> lcd_mode == lmtc_pkg::MODE_VBLANK)
    else $error("vblank pulse without vblank mode");

  a_draw_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && draw_request |-> lcd_mode == lmtc_pkg::MODE_HBLANK && !vblank_irq)
    else $error("draw request outside hblank entry");

  // the first edge out of reset shows no result beat
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  // an open pipe never stalls the input side
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind lcd_mode_timing_controller_top lmtc_checker u_lmtc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .lcd_mode     (lcd_mode),
  .current_line (current_line),
  .vblank_irq   (vblank_irq),
  .draw_request (draw_request)
);

`default_nettype wire

>>> verif/tb_lcd_mode_timing_controller_top.sv
`timescale 1ns / 100ps

module tb_lcd_mode_timing_controller_top;

  localparam int LINE_CYCLES = 456;
  localparam int TOTAL_LINES = 154;
  localparam int VISIBLE_LINES = 144;
  localparam int OAM_END = 80;
  localparam int TRANSFER_END = 252;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BEATS = 325;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [lmtc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lmtc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [lmtc_pkg::ELAPSED_W-1:0] elapsed_cycles = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] lcd_mode;
  lmtc_pkg::line_t current_line;
  logic coincidence;
  logic vblank_irq;
  logic stat_irq;
  logic draw_request;

  lcd_mode_timing_controller_top #(
    .LINE_CYCLES(LINE_CYCLES),
    .TOTAL_LINES(TOTAL_LINES),
    .VISIBLE_LINES(VISIBLE_LINES),
    .OAM_END(OAM_END),
    .TRANSFER_END(TRANSFER_END)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .elapsed_cycles(elapsed_cycles),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .lcd_mode(lcd_mode),
    .current_line(current_line),
    .coincidence(coincidence),
    .vblank_irq(vblank_irq),
    .stat_irq(stat_irq),
    .draw_request(draw_request)
  );

  // shadow of the timing state and of the register file
  int unsigned line_pos;
  lmtc_pkg::line_t scan_line;
  lmtc_pkg::mode_t scan_mode;
  logic coin_flag;
  lmtc_pkg::line_t cmp_line;
  logic coin_en;
  logic oam_en;
  logic vblank_en;
  logic hblank_en;

  // directed: field extremes, walk OAM -> transfer -> hblank on exact edges
  logic [lmtc_pkg::ELAPSED_W-1:0] directed_steps[24] = '{
    8'd0, 8'd255, 8'd255, 8'd25, 8'd1, 8'd171, 8'd1, 8'd0, 8'd203,
    8'd1, 8'd80, 8'd172, 8'd170, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h04,
    8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFF
  };

  logic [lmtc_pkg::ELAPSED_W-1:0] elapsed_q[$];
  lmtc_pkg::result_t status_q[$];
  lmtc_pkg::result_t want;
  int errors = 0;
  int cycles_run = 0;
  int send_hold = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic lmtc_pkg::result_t advance_timing(
    input logic [lmtc_pkg::ELAPSED_W-1:0] elapsed);
    int unsigned sum;
    lmtc_pkg::result_t r;
    sum = line_pos + elapsed;
    r = '0;
    if (sum >= LINE_CYCLES) begin
      sum -= LINE_CYCLES;
      scan_line = lmtc_pkg::line_t'((scan_line + 1) % TOTAL_LINES);
      coin_flag = (scan_line == cmp_line);
      if (coin_flag && coin_en) r.stat_irq = 1'b1;
      if (scan_line == VISIBLE_LINES) begin
        scan_mode = lmtc_pkg::MODE_VBLANK;
        r.vblank_irq = 1'b1;
        // OAM enable also fires on vblank entry
        if (vblank_en || oam_en) r.stat_irq = 1'b1;
      end else if (scan_line < VISIBLE_LINES) begin
        scan_mode = lmtc_pkg::MODE_OAM;
        if (oam_en) r.stat_irq = 1'b1;
      end
    end else if (scan_mode == lmtc_pkg::MODE_OAM && sum >= OAM_END) begin
      scan_mode = lmtc_pkg::MODE_XFER;
    end else if (scan_mode == lmtc_pkg::MODE_XFER && sum >= TRANSFER_END) begin
      scan_mode = lmtc_pkg::MODE_HBLANK;
      r.draw = 1'b1;
      if (hblank_en) r.stat_irq = 1'b1;
    end
    line_pos = (sum > lmtc_pkg::COUNT_MAX) ? lmtc_pkg::COUNT_MAX : sum;
    r.mode = scan_mode;
    r.line = scan_line;
    r.coincidence = coin_flag;
    return r;
  endfunction

  task automatic write_reg(input logic [lmtc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lmtc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lmtc_pkg::REG_LINE_COMPARE: cmp_line = val;
      lmtc_pkg::REG_COIN_IRQ_EN: coin_en = val[0];
      lmtc_pkg::REG_OAM_IRQ_EN: oam_en = val[0];
      lmtc_pkg::REG_VBLANK_IRQ_EN: vblank_en = val[0];
      lmtc_pkg::REG_HBLANK_IRQ_EN: hblank_en = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] cmp, input logic [7:0] coin,
                            input logic [7:0] oam, input logic [7:0] vb,
                            input logic [7:0] hb);
    write_reg(lmtc_pkg::REG_LINE_COMPARE, cmp);
    write_reg(lmtc_pkg::REG_COIN_IRQ_EN, coin);
    write_reg(lmtc_pkg::REG_OAM_IRQ_EN, oam);
    write_reg(lmtc_pkg::REG_VBLANK_IRQ_EN, vb);
    write_reg(lmtc_pkg::REG_HBLANK_IRQ_EN, hb);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (elapsed_q.size() != 0 || in_valid || status_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(input int n);
    logic [lmtc_pkg::ELAPSED_W-1:0] e;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: e = 8'($urandom_range(0, 255));
        4, 5, 6: e = 8'($urandom_range(0, 24));   // fine steps walk through each mode
        7: e = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        default: e = 8'($urandom_range(60, 200));
      endcase
      elapsed_q.push_back(e);
    end
    wait_drained();
  endtask

  initial begin
    line_pos = 0;
    scan_line = '0;
    scan_mode = lmtc_pkg::MODE_HBLANK;
    coin_flag = 1'b0;
    cmp_line = '0;
    coin_en = 1'b0;
    oam_en = 1'b0;
    vblank_en = 1'b0;
    hblank_en = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i])
      elapsed_q.push_back(directed_steps[i]);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config(8'd255, 8'd1, 8'd1, 8'd1, 8'd1);
        1: set_config(8'd0, 8'd1, 8'd1, 8'd0, 8'd0);
        2: set_config(8'd144, 8'd1, 8'd0, 8'd1, 8'd1);
        3: set_config(8'd153, 8'hFE, 8'hFF, 8'd0, 8'd1);
        default: begin
          // compare a little ahead of the current line so a match shows up soon
          set_config(8'((scan_line + $urandom_range(1, 40)) % TOTAL_LINES),
                     8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          write_reg(lmtc_pkg::REG_HBLANK_IRQ_EN + 3'($urandom_range(1, 3)),
                    8'($urandom));
        end
      endcase
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      run_random(PHASE_BEATS);
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_hold <= 0;
    end else begin
      if (in_valid && !in_stall) status_q.push_back(advance_timing(elapsed_cycles));
      if (!in_valid || !in_stall) begin
        if (send_hold > 0) begin
          send_hold <= send_hold - 1;
          in_valid <= 1'b0;
        end else if (elapsed_q.size() != 0 && !calm && $urandom_range(0, 11) == 0) begin
          send_hold <= $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else if (elapsed_q.size() != 0) begin
          in_valid <= 1'b1;
          elapsed_cycles <= elapsed_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $error("unexpected result beat: mode %0d line %0d", lcd_mode, current_line);
          errors++;
        end else begin
          want = status_q.pop_front();
          if (lcd_mode !== want.mode) begin
            $error("lcd_mode: expected %0d, actual %0d", want.mode, lcd_mode);
            errors++;
          end
          if (current_line !== want.line) begin
            $error("current_line: expected %0d, actual %0d", want.line, current_line);
            errors++;
          end
          if (coincidence !== want.coincidence) begin
            $error("coincidence: expected %0d, actual %0d", want.coincidence, coincidence);
            errors++;
          end
          if (vblank_irq !== want.vblank_irq) begin
            $error("vblank_irq: expected %0d, actual %0d", want.vblank_irq, vblank_irq);
            errors++;
          end
          if (stat_irq !== want.stat_irq) begin
            $error("stat_irq: expected %0d, actual %0d", want.stat_irq, stat_irq);
            errors++;
          end
          if (draw_request !== want.draw) begin
            $error("draw_request: expected %0d, actual %0d", want.draw, draw_request);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left <= $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

>>> lcd_mode_timing_controller_top.f
src/lmtc_pkg.sv
src/lmtc_cfg_regs.sv
src/lmtc_line_seq.sv
src/lcd_mode_timing_controller_top.sv
src/lmtc_checker.sv
verif/tb_lcd_mode_timing_controller_top.sv
